[hw/rtl/dlr_pkg.sv]
package dlr_pkg;

    localparam int COORD_W         = 24;
    localparam int COORD_FRAC_BITS = 8;
    localparam int STEP_FRAC_BITS  = 16;
    localparam int POS_FRAC        = COORD_FRAC_BITS + STEP_FRAC_BITS;
    localparam int Z_W             = 16;
    localparam int DELTA_W         = COORD_W + 1;
    localparam int POS_W           = COORD_W + STEP_FRAC_BITS + 2;
    localparam int INC_W           = POS_FRAC + 2;
    localparam int QUOT_W          = POS_FRAC + 1;
    localparam int DIV_CNT_W       = $clog2(QUOT_W + 1);
    localparam int PIX_W           = 12;
    localparam int PIX_IDX_W       = POS_W - 1 - POS_FRAC;
    localparam int SCR_W           = 13;
    localparam int COLOR_W         = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [SCR_W-1:0]   SCREEN_LIMIT       = SCR_W'(4096);
    localparam logic [SCR_W-1:0]   RST_SCREEN_WIDTH   = SCR_W'(1920);
    localparam logic [SCR_W-1:0]   RST_SCREEN_HEIGHT  = SCR_W'(1080);
    localparam logic [Z_W-1:0]     RST_GROUND_LEVEL   = '0;
    localparam logic [COLOR_W-1:0] RST_COLOR_FLAT     = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] RST_COLOR_RAISED   = 32'hFF00_00FF;
    localparam logic [COLOR_W-1:0] RST_COLOR_SLOPE    = 32'h00FF_00FF;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_GROUND_LEVEL  = 3'd2,
        CFG_COLOR_FLAT    = 3'd3,
        CFG_COLOR_RAISED  = 3'd4,
        CFG_COLOR_SLOPE   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_X,
        ST_DIV_Y,
        ST_STEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                      cmd;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [Z_W-1:0]     start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [Z_W-1:0]     end_z;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               pixel_valid;
        logic               line_done;
    } pixel_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_wr_t;

    typedef struct packed {
        logic [SCR_W-1:0]      screen_width;
        logic [SCR_W-1:0]      screen_height;
        logic signed [Z_W-1:0] ground_level;
        logic [COLOR_W-1:0]    color_flat;
        logic [COLOR_W-1:0]    color_raised;
        logic [COLOR_W-1:0]    color_slope;
    } cfg_regs_t;

    typedef struct packed {
        logic               start;
        logic [DELTA_W-1:0] num;
        logic [DELTA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

[hw/rtl/dlr_item_if.sv]
interface dlr_item_if;
    logic            valid;
    logic            ready;
    dlr_pkg::item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dlr_pixel_if.sv]
interface dlr_pixel_if;
    logic             valid;
    logic             ready;
    dlr_pkg::pixel_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dlr_cfg_if.sv]
interface dlr_cfg_if;
    logic              valid;
    logic              ready;
    dlr_pkg::cfg_wr_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dlr_cfg_regs.sv]
module dlr_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    dlr_cfg_if.sink             cfg,
    output dlr_pkg::cfg_regs_t  regs
);

    dlr_pkg::cfg_regs_t regs_reg;
    dlr_pkg::cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.data.index)
                dlr_pkg::CFG_SCREEN_WIDTH:
                    regs_next.screen_width = cfg.data.value[dlr_pkg::SCR_W-1:0];
                dlr_pkg::CFG_SCREEN_HEIGHT:
                    regs_next.screen_height = cfg.data.value[dlr_pkg::SCR_W-1:0];
                dlr_pkg::CFG_GROUND_LEVEL:
                    regs_next.ground_level = $signed(cfg.data.value[dlr_pkg::Z_W-1:0]);
                dlr_pkg::CFG_COLOR_FLAT:
                    regs_next.color_flat = cfg.data.value[dlr_pkg::COLOR_W-1:0];
                dlr_pkg::CFG_COLOR_RAISED:
                    regs_next.color_raised = cfg.data.value[dlr_pkg::COLOR_W-1:0];
                dlr_pkg::CFG_COLOR_SLOPE:
                    regs_next.color_slope = cfg.data.value[dlr_pkg::COLOR_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.screen_width  <= dlr_pkg::RST_SCREEN_WIDTH;
            regs_reg.screen_height <= dlr_pkg::RST_SCREEN_HEIGHT;
            regs_reg.ground_level  <= $signed(dlr_pkg::RST_GROUND_LEVEL);
            regs_reg.color_flat    <= dlr_pkg::RST_COLOR_FLAT;
            regs_reg.color_raised  <= dlr_pkg::RST_COLOR_RAISED;
            regs_reg.color_slope   <= dlr_pkg::RST_COLOR_SLOPE;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[hw/rtl/dlr_divider.sv]
module dlr_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  dlr_pkg::div_req_t  req,
    output dlr_pkg::div_rsp_t  rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [dlr_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [dlr_pkg::DELTA_W-1:0]    rem_reg, rem_next;
    logic [dlr_pkg::DELTA_W-1:0]    den_reg, den_next;
    logic [dlr_pkg::QUOT_W-1:0]     shf_reg, shf_next;
    logic [dlr_pkg::QUOT_W-1:0]     quot_reg, quot_next;

    logic [dlr_pkg::DELTA_W:0]      trial;
    logic [dlr_pkg::DELTA_W:0]      trial_sub;
    logic                           ge;

    // restoring step: shift in one dividend bit, try to subtract the divisor
    always_comb
    begin
        trial     = {rem_reg, shf_reg[dlr_pkg::QUOT_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        shf_next  = shf_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            // dividend is num << POS_FRAC; its top part num >> 1 is already below den
            busy_next = 1'b1;
            cnt_next  = dlr_pkg::DIV_CNT_W'(dlr_pkg::QUOT_W);
            rem_next  = {1'b0, req.num[dlr_pkg::DELTA_W-1:1]};
            shf_next  = {req.num[0], {dlr_pkg::POS_FRAC{1'b0}}};
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial_sub[dlr_pkg::DELTA_W-1:0] : trial[dlr_pkg::DELTA_W-1:0];
            shf_next  = {shf_reg[dlr_pkg::QUOT_W-2:0], 1'b0};
            quot_next = {quot_reg[dlr_pkg::QUOT_W-2:0], ge};
            cnt_next  = cnt_reg - dlr_pkg::DIV_CNT_W'(1);
            if (cnt_reg == dlr_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        shf_reg  <= shf_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

endmodule

[hw/rtl/dda_line_rasterizer_unit.sv]
// dda line rasterizer
// item channel: cmd 0 loads a line from two signed Q15.8 end points and
// their heights; cmd 1 asks for the next pixel of the current line.
// every item gives exactly one beat on the pixel channel: a start beat
// carries the line color and line_done when the line is shorter than one
// pixel; a step beat carries the current point (pixel_valid only when it
// lies on screen) and line_done on its last point or with no line active.
// cfg channel writes screen size, ground level and the three colors; it is
// always ready and is meant to be used only while no item is in flight.
// a start item passes a setup state, then one restoring divider, shared by
// both axes, makes one quotient bit per cycle, a 25-bit quotient for each
// axis in turn; a line shorter than a pixel skips the divides. a step item
// advances the point, then does the end check and result load. the next
// item is taken only after the result is loaded. item.ready is high only
// between items, also while a result still waits in the output register.
// if the receiver stalls, the last beat stays in the output register and
// the next result waits in the finish state before it is released.
// reset restores the default registers and leaves no line active.
module dda_line_rasterizer_unit (
    input  logic          clk,
    input  logic          rst_n,
    dlr_item_if.sink      item,
    dlr_pixel_if.source   pixel,
    dlr_cfg_if.sink       cfg
);

    localparam logic signed [dlr_pkg::DELTA_W-1:0] COORD_ONE =
        dlr_pkg::DELTA_W'(2 ** dlr_pkg::COORD_FRAC_BITS);
    localparam logic signed [dlr_pkg::POS_W-1:0] POS_ONE =
        dlr_pkg::POS_W'(2 ** dlr_pkg::POS_FRAC);

    dlr_pkg::cfg_regs_t  cfg_regs;
    dlr_pkg::div_req_t   div_req;
    dlr_pkg::div_rsp_t   div_rsp;

    dlr_pkg::state_t     state_reg, state_next;

    logic signed [dlr_pkg::POS_W-1:0]    cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic signed [dlr_pkg::POS_W-1:0]    diff_x_reg, diff_x_next, diff_y_reg, diff_y_next;
    logic signed [dlr_pkg::INC_W-1:0]    inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic signed [dlr_pkg::DELTA_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [dlr_pkg::DELTA_W-1:0]         mag_y_reg, mag_y_next, big_reg, big_next;
    logic [dlr_pkg::COLOR_W-1:0]         color_reg, color_next;
    logic                                active_reg, active_next;
    logic                                chk_reg, chk_next;
    dlr_pkg::pixel_t                     res_reg, res_next;
    dlr_pkg::pixel_t                     out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic                                item_fire;
    logic                                out_free;
    logic [dlr_pkg::DELTA_W-1:0]         mag_x, mag_y, big;
    logic                                start_over;
    logic [dlr_pkg::COLOR_W-1:0]         new_color;
    logic signed [dlr_pkg::INC_W-1:0]    quot_ext, inc_from_div;
    logic [dlr_pkg::SCR_W-1:0]           lim_w, lim_h;
    logic [dlr_pkg::PIX_IDX_W-1:0]       idx_x, idx_y;
    logic                                on_screen;
    logic                                near_x, near_y, passed_x, passed_y, over_now;

    dlr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    dlr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_fire   = item.valid && item.ready;
    assign out_free    = !out_valid_reg || pixel.ready;
    assign item.ready  = (state_reg == dlr_pkg::ST_IDLE);
    assign pixel.valid = out_valid_reg;
    assign pixel.data  = out_reg;

    // line color from the two heights
    always_comb
    begin
        if ((item.data.start_z != cfg_regs.ground_level ||
             item.data.end_z != cfg_regs.ground_level) &&
            item.data.start_z != item.data.end_z)
        begin
            new_color = cfg_regs.color_slope;
        end
        else if (item.data.start_z != cfg_regs.ground_level &&
                 item.data.end_z != cfg_regs.ground_level)
        begin
            new_color = cfg_regs.color_raised;
        end
        else
        begin
            new_color = cfg_regs.color_flat;
        end
    end

    // deltas, major axis and the sub-pixel test
    always_comb
    begin
        mag_x = dlr_pkg::DELTA_W'(dx_reg[dlr_pkg::DELTA_W-1] ? -dx_reg : dx_reg);
        mag_y = dlr_pkg::DELTA_W'(dy_reg[dlr_pkg::DELTA_W-1] ? -dy_reg : dy_reg);
        big   = (mag_x > mag_y) ? mag_x : mag_y;
        start_over = (dx_reg > -COORD_ONE) && (dx_reg < COORD_ONE) &&
                     (dy_reg > -COORD_ONE) && (dy_reg < COORD_ONE);
    end

    // quotient magnitude back to a signed increment
    always_comb
    begin
        quot_ext     = dlr_pkg::INC_W'(div_rsp.quot);
        inc_from_div = quot_ext;
        if (state_reg == dlr_pkg::ST_DIV_X && dx_reg[dlr_pkg::DELTA_W-1])
        begin
            inc_from_div = -quot_ext;
        end
        else if (state_reg == dlr_pkg::ST_DIV_Y && dy_reg[dlr_pkg::DELTA_W-1])
        begin
            inc_from_div = -quot_ext;
        end
    end

    // clipping of the current point
    always_comb
    begin
        lim_w = (cfg_regs.screen_width > dlr_pkg::SCREEN_LIMIT) ?
                dlr_pkg::SCREEN_LIMIT : cfg_regs.screen_width;
        lim_h = (cfg_regs.screen_height > dlr_pkg::SCREEN_LIMIT) ?
                dlr_pkg::SCREEN_LIMIT : cfg_regs.screen_height;
        idx_x = cur_x_reg[dlr_pkg::POS_W-2:dlr_pkg::POS_FRAC];
        idx_y = cur_y_reg[dlr_pkg::POS_W-2:dlr_pkg::POS_FRAC];
        on_screen = !cur_x_reg[dlr_pkg::POS_W-1] && !cur_y_reg[dlr_pkg::POS_W-1] &&
                    (idx_x < dlr_pkg::PIX_IDX_W'(lim_w)) &&
                    (idx_y < dlr_pkg::PIX_IDX_W'(lim_h));
    end

    // end of line: both remaining distances below a pixel, or an axis overshot
    always_comb
    begin
        near_x   = (diff_x_reg > -POS_ONE) && (diff_x_reg < POS_ONE);
        near_y   = (diff_y_reg > -POS_ONE) && (diff_y_reg < POS_ONE);
        passed_x = (!inc_x_reg[dlr_pkg::INC_W-1] && inc_x_reg != '0 &&
                    diff_x_reg <= -POS_ONE) ||
                   (inc_x_reg[dlr_pkg::INC_W-1] && diff_x_reg >= POS_ONE);
        passed_y = (!inc_y_reg[dlr_pkg::INC_W-1] && inc_y_reg != '0 &&
                    diff_y_reg <= -POS_ONE) ||
                   (inc_y_reg[dlr_pkg::INC_W-1] && diff_y_reg >= POS_ONE);
        over_now = (near_x && near_y) || passed_x || passed_y;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (item.data.cmd == dlr_pkg::CMD_START)
                    begin
                        state_next = dlr_pkg::ST_PREP;
                    end
                    else if (active_reg)
                    begin
                        state_next = dlr_pkg::ST_STEP;
                    end
                    else
                    begin
                        state_next = dlr_pkg::ST_FINISH;
                    end
                end
            end
            dlr_pkg::ST_PREP:
            begin
                state_next = start_over ? dlr_pkg::ST_FINISH : dlr_pkg::ST_DIV_X;
            end
            dlr_pkg::ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    state_next = dlr_pkg::ST_DIV_Y;
                end
            end
            dlr_pkg::ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    state_next = dlr_pkg::ST_FINISH;
                end
            end
            dlr_pkg::ST_STEP:
            begin
                state_next = dlr_pkg::ST_FINISH;
            end
            dlr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        diff_x_next    = diff_x_reg;
        diff_y_next    = diff_y_reg;
        inc_x_next     = inc_x_reg;
        inc_y_next     = inc_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        mag_y_next     = mag_y_reg;
        big_next       = big_reg;
        color_next     = color_reg;
        active_next    = active_reg;
        chk_next       = chk_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pixel.ready;

        div_req.start = 1'b0;
        div_req.num   = mag_y_reg;
        div_req.den   = big_reg;

        case (state_reg)
            dlr_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    res_next.pixel_x     = '0;
                    res_next.pixel_y     = '0;
                    res_next.pixel_valid = 1'b0;
                    res_next.line_done   = 1'b1;
                    chk_next             = 1'b0;
                    if (item.data.cmd == dlr_pkg::CMD_START)
                    begin
                        cur_x_next = dlr_pkg::POS_W'($signed(item.data.start_x))
                                     <<< dlr_pkg::STEP_FRAC_BITS;
                        cur_y_next = dlr_pkg::POS_W'($signed(item.data.start_y))
                                     <<< dlr_pkg::STEP_FRAC_BITS;
                        dx_next = dlr_pkg::DELTA_W'($signed(item.data.end_x)) -
                                  dlr_pkg::DELTA_W'($signed(item.data.start_x));
                        dy_next = dlr_pkg::DELTA_W'($signed(item.data.end_y)) -
                                  dlr_pkg::DELTA_W'($signed(item.data.start_y));
                        color_next = new_color;
                    end
                end
            end
            dlr_pkg::ST_PREP:
            begin
                diff_x_next = dlr_pkg::POS_W'(dx_reg) <<< dlr_pkg::STEP_FRAC_BITS;
                diff_y_next = dlr_pkg::POS_W'(dy_reg) <<< dlr_pkg::STEP_FRAC_BITS;
                mag_y_next  = mag_y;
                big_next    = big;
                active_next = !start_over;
                res_next.line_done = start_over;
                div_req.start = !start_over;
                div_req.num   = mag_x;
                div_req.den   = big;
            end
            dlr_pkg::ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    inc_x_next    = inc_from_div;
                    div_req.start = 1'b1;
                end
            end
            dlr_pkg::ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    inc_y_next = inc_from_div;
                end
            end
            dlr_pkg::ST_STEP:
            begin
                res_next.pixel_valid = on_screen;
                res_next.pixel_x = on_screen ? idx_x[dlr_pkg::PIX_W-1:0] : '0;
                res_next.pixel_y = on_screen ? idx_y[dlr_pkg::PIX_W-1:0] : '0;
                cur_x_next  = cur_x_reg + dlr_pkg::POS_W'(inc_x_reg);
                cur_y_next  = cur_y_reg + dlr_pkg::POS_W'(inc_y_reg);
                diff_x_next = diff_x_reg - dlr_pkg::POS_W'(inc_x_reg);
                diff_y_next = diff_y_reg - dlr_pkg::POS_W'(inc_y_reg);
                chk_next    = 1'b1;
            end
            dlr_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_next             = res_reg;
                    out_next.pixel_color = color_reg;
                    out_next.line_done   = chk_reg ? over_now : res_reg.line_done;
                    out_valid_next       = 1'b1;
                    if (chk_reg && over_now)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            default:
            begin
                chk_next = chk_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlr_pkg::ST_IDLE;
            active_reg    <= 1'b0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
            color_reg     <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        diff_x_reg <= diff_x_next;
        diff_y_reg <= diff_y_next;
        inc_x_reg  <= inc_x_next;
        inc_y_reg  <= inc_y_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        mag_y_reg  <= mag_y_next;
        big_reg    <= big_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    a_start_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && item.data.cmd == dlr_pkg::CMD_START) |=> state_reg == dlr_pkg::ST_PREP)
        else $error("start beat did not enter setup");

    a_clipped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && !pixel.data.pixel_valid) |->
            (pixel.data.pixel_x == '0 && pixel.data.pixel_y == '0))
        else $error("clipped pixel carries coordinates");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == dlr_pkg::ST_DIV_X || state_reg == dlr_pkg::ST_DIV_Y))
        else $error("quotient arrived outside a divide phase");

    a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dlr_pkg::ST_STEP |-> active_reg)
        else $error("advancing without an active line");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlr_pkg::ST_FINISH && out_free) |=> out_valid_reg)
        else $error("result not loaded into output register");

endmodule
